>>> design/assert_macros.svh
// Assertion helpers used by the segment downsampler
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define SD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/sd_pkg.sv
package sd_pkg;

	// Field and register widths
	localparam int SAMPLE_W    = 8;
	localparam int FACTOR_W    = 7;
	localparam int MODE_W      = 2;
	localparam int SCAN_LEN_W  = 17;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 17;

	// Mode codes; any other code selects the first sample of the segment
	localparam logic [MODE_W-1:0] MODE_MEAN   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_MEDIAN = 2'd1;

	// Register indexes on the configuration port
	localparam logic [CFG_INDEX_W-1:0] REG_FACTOR   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MODE     = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SCAN_LEN = 2'd2;

	// Register reset values
	localparam logic [FACTOR_W-1:0]   FACTOR_RST   = 7'd1;
	localparam logic [MODE_W-1:0]     MODE_RST     = MODE_MEAN;
	localparam logic [SCAN_LEN_W-1:0] SCAN_LEN_RST = 17'h10000;

	// Operation of the shared arithmetic unit
	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

endpackage

>>> design/sd_alu.sv
module sd_alu #(
	parameter int W = 16
) (
	input  sd_pkg::alu_op_t    op,
	input  logic signed [W-1:0] a,
	input  logic signed [W-1:0] b,
	output logic signed [W-1:0] y
);

	// Single add/subtract shared by insertion compare, magnitude and sign, division and averaging
	always_comb begin
		unique case (op)
			sd_pkg::ALU_SUB: y = a - b;
			sd_pkg::ALU_ADD: y = a + b;
			default:         y = a + b;
		endcase
	end

endmodule

>>> design/sd_store.sv
module sd_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int DW    = 8
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic signed [DW-1:0] wdata,
	input  logic [AW-1:0]        raddr,
	output logic signed [DW-1:0] rdata
);

	logic signed [DW-1:0] store_q [DEPTH];
	logic signed [DW-1:0] rdata_q;

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			store_q[waddr] <= wdata;
		end
		rdata_q <= store_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> design/segment_downsampler.sv
// Segment downsampler: groups signed 8-bit samples of consecutive scans into
// segments of factor samples and emits one value per full segment (mean,
// median or first sample); a trailing partial segment of a scan is dropped.
// Channels: sample_valid/sample_stall carry input samples, result_valid/
// result_stall carry value and last_of_scan. A beat moves when valid is high
// and stall is low. The configuration port (cfg_valid/cfg_ready, cfg_index,
// cfg_data) writes factor, mode and scan_length; any write restarts the scan.
// Structure: one sequencer drives a shared adder/subtractor and a sorted
// segment store with one write port and one registered read port. A sample
// is stored by sorted insertion in median mode, walking down past the larger
// stored samples. At a segment end the result is the first sample, the mean
// by restoring division (one quotient bit per cycle) and a sign step, or the
// median from the middle entry or the halved sum of the middle pair; it is
// then handed to the output register once that register is free.
// sample_stall is high while an item is at work.
// While the receiver stalls, the finished result stays in the output
// register and the next sample is still taken; a second result then waits
// until the first beat leaves. Reset clears the scan and sets factor 1,
// mean mode and scan length 65536; the segment store needs no clearing.
module segment_downsampler #(
	parameter int MAX_FACTOR   = 64,
	parameter int MAX_SCAN_LEN = 65536
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   sample_valid,
	output logic                                   sample_stall,
	input  logic signed [sd_pkg::SAMPLE_W-1:0]     sample,
	output logic                                   result_valid,
	input  logic                                   result_stall,
	output logic signed [sd_pkg::SAMPLE_W-1:0]     value,
	output logic                                   last_of_scan,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [sd_pkg::CFG_INDEX_W-1:0]         cfg_index,
	input  logic [sd_pkg::CFG_DATA_W-1:0]          cfg_data
);

`include "assert_macros.svh"

	localparam int SMP_W = sd_pkg::SAMPLE_W;
	localparam int FW    = $clog2(MAX_FACTOR + 1);
	localparam int AW    = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
	localparam int SW    = SMP_W + $clog2(MAX_FACTOR);
	localparam int LW    = $clog2(MAX_SCAN_LEN + 1);
	localparam int ALU_W = SW + 2;
	localparam int CW    = $clog2(SW + 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_SEG,
		ST_DIV,
		ST_SIGN,
		ST_MED_RD,
		ST_MED_PAIR,
		ST_MED_AVG,
		ST_DONE
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [sd_pkg::FACTOR_W-1:0]   factor_q;
	logic [sd_pkg::MODE_W-1:0]     mode_q;
	logic [sd_pkg::SCAN_LEN_W-1:0] scan_len_q;

	// Scan and segment progress
	logic [FW-1:0]          fill_q;
	logic signed [SW-1:0]   sum_q;
	logic [LW-1:0]          pos_q;

	// Per-item work registers
	logic signed [SMP_W-1:0] smp_q;
	logic signed [SMP_W-1:0] first_q;
	logic                    done_q;
	logic                    lastf_q;
	logic                    neg_q;
	logic [SW-1:0]           dvd_q;
	logic [FW-1:0]           rem_q;
	logic [CW-1:0]           cnt_q;
	logic [AW-1:0]           j_q;
	logic signed [SMP_W-1:0] pair_q;
	logic signed [SMP_W-1:0] res_q;

	// Output register
	logic                    out_valid_q;
	logic signed [SMP_W-1:0] value_q;
	logic                    out_last_q;

	// Effective factor and scan length
	logic [31:0]   f_eff_w;
	logic [31:0]   len_eff_w;
	logic [FW-1:0] f_eff;
	logic [LW-1:0] len_eff;
	logic [AW-1:0] half;

	always_comb begin
		priority if (factor_q == '0) begin
			f_eff_w = 32'd1;
		end else if (32'(factor_q) > 32'(MAX_FACTOR)) begin
			f_eff_w = 32'(MAX_FACTOR);
		end else begin
			f_eff_w = 32'(factor_q);
		end
		priority if (scan_len_q == '0) begin
			len_eff_w = 32'd1;
		end else if (32'(scan_len_q) > 32'(MAX_SCAN_LEN)) begin
			len_eff_w = 32'(MAX_SCAN_LEN);
		end else begin
			len_eff_w = 32'(scan_len_q);
		end
	end

	assign f_eff   = f_eff_w[FW-1:0];
	assign len_eff = len_eff_w[LW-1:0];
	assign half    = AW'(f_eff >> 1);

	// Bookkeeping for an accepted sample
	logic [FW-1:0]        fill_n;
	logic [LW-1:0]        pos_n;
	logic signed [SW-1:0] sum_n;
	logic                 seg_done;
	logic                 scan_end;
	logic                 last_n;

	assign fill_n   = fill_q + FW'(1);
	assign pos_n    = pos_q + LW'(1);
	assign sum_n    = sum_q + SW'(sample);
	assign seg_done = (fill_n >= f_eff);
	assign scan_end = (pos_n >= len_eff);
	assign last_n   = (32'(len_eff - pos_n) < 32'(f_eff));

	// Handshakes; a sample on offer goes ahead of a register write
	logic sample_acc;
	logic cfg_hit;

	assign sample_stall = (state_q != ST_IDLE);
	assign cfg_ready    = (state_q == ST_IDLE) && !sample_valid;
	assign sample_acc   = sample_valid && !sample_stall;
	assign cfg_hit      = cfg_valid && cfg_ready &&
		((cfg_index == sd_pkg::REG_FACTOR) || (cfg_index == sd_pkg::REG_MODE) ||
		 (cfg_index == sd_pkg::REG_SCAN_LEN));

	// Shared unit and sorted store
	sd_pkg::alu_op_t        alu_op;
	logic signed [ALU_W-1:0] alu_a;
	logic signed [ALU_W-1:0] alu_b;
	logic signed [ALU_W-1:0] alu_y;

	logic                    mem_we;
	logic [AW-1:0]           mem_waddr;
	logic signed [SMP_W-1:0] mem_wdata;
	logic [AW-1:0]           mem_raddr;
	logic signed [SMP_W-1:0] mem_rdata;

	sd_alu #(
		.W(ALU_W)
	) u_alu (
		.op(alu_op),
		.a (alu_a),
		.b (alu_b),
		.y (alu_y)
	);

	sd_store #(
		.DEPTH(MAX_FACTOR),
		.AW   (AW),
		.DW   (SMP_W)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	logic            ins_gt;
	logic            qbit;
	logic [FW:0]     div_shift;
	logic signed [SMP_W:0] med_sum;
	logic signed [SMP_W:0] med_adj;

	assign ins_gt    = alu_y[ALU_W-1];
	assign qbit      = !alu_y[ALU_W-1];
	assign div_shift = {rem_q, dvd_q[SW-1]};
	assign med_sum   = alu_y[SMP_W:0];
	assign med_adj   = med_sum + {{SMP_W{1'b0}}, med_sum[SMP_W]};

	// Steer the shared unit and the store port per state
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = j_q;
		mem_wdata = smp_q;
		mem_raddr = j_q - AW'(1);
		alu_op    = sd_pkg::ALU_SUB;
		alu_a     = '0;
		alu_b     = '0;
		unique case (state_q)
			ST_INS_RD: begin
				// Head of the store reached: drop the sample in place
				if (j_q == '0) begin
					mem_we = 1'b1;
				end
			end
			ST_INS_CMP: begin
				alu_a     = ALU_W'(smp_q);
				alu_b     = ALU_W'(mem_rdata);
				mem_we    = 1'b1;
				mem_wdata = ins_gt ? mem_rdata : smp_q;
			end
			ST_SEG: begin
				// Magnitude of the segment sum
				alu_op = neg_q ? sd_pkg::ALU_SUB : sd_pkg::ALU_ADD;
				alu_b  = ALU_W'(signed'(dvd_q));
			end
			ST_DIV: begin
				alu_a = ALU_W'(div_shift);
				alu_b = ALU_W'(f_eff);
			end
			ST_SIGN: begin
				alu_op = neg_q ? sd_pkg::ALU_SUB : sd_pkg::ALU_ADD;
				alu_b  = ALU_W'(dvd_q);
			end
			ST_MED_RD: begin
				mem_raddr = f_eff[0] ? half : (half - AW'(1));
			end
			ST_MED_PAIR: begin
				mem_raddr = half;
			end
			ST_MED_AVG: begin
				alu_op = sd_pkg::ALU_ADD;
				alu_a  = ALU_W'(pair_q);
				alu_b  = ALU_W'(mem_rdata);
			end
			default: begin
			end
		endcase
	end

	// Sequencer, progress counters and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			factor_q    <= sd_pkg::FACTOR_RST;
			mode_q      <= sd_pkg::MODE_RST;
			scan_len_q  <= sd_pkg::SCAN_LEN_RST;
			fill_q      <= '0;
			sum_q       <= '0;
			pos_q       <= '0;
			smp_q       <= '0;
			first_q     <= '0;
			done_q      <= 1'b0;
			lastf_q     <= 1'b0;
			neg_q       <= 1'b0;
			dvd_q       <= '0;
			rem_q       <= '0;
			cnt_q       <= '0;
			j_q         <= '0;
			pair_q      <= '0;
			res_q       <= '0;
			out_valid_q <= 1'b0;
			value_q     <= '0;
			out_last_q  <= 1'b0;
		end else begin
			// Drop the result once its beat leaves
			if (out_valid_q && !result_stall && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (sample_acc) begin
						smp_q   <= sample;
						j_q     <= AW'(fill_q);
						done_q  <= seg_done;
						lastf_q <= last_n;
						dvd_q   <= sum_n;
						neg_q   <= sum_n[SW-1];
						if (fill_q == '0) begin
							first_q <= sample;
						end
						sum_q  <= (seg_done || scan_end) ? '0 : sum_n;
						fill_q <= (seg_done || scan_end) ? '0 : fill_n;
						pos_q  <= scan_end ? '0 : pos_n;
						state_q <= (mode_q == sd_pkg::MODE_MEDIAN) ? ST_INS_RD : ST_SEG;
					end
				end
				ST_INS_RD: begin
					state_q <= (j_q == '0) ? ST_SEG : ST_INS_CMP;
				end
				ST_INS_CMP: begin
					// Shift the larger entry up and keep walking down
					if (ins_gt) begin
						j_q     <= j_q - AW'(1);
						state_q <= ST_INS_RD;
					end else begin
						state_q <= ST_SEG;
					end
				end
				ST_SEG: begin
					if (!done_q) begin
						state_q <= ST_IDLE;
					end else if (mode_q == sd_pkg::MODE_MEAN) begin
						dvd_q   <= alu_y[SW-1:0];
						rem_q   <= '0;
						cnt_q   <= CW'(SW);
						state_q <= ST_DIV;
					end else if (mode_q == sd_pkg::MODE_MEDIAN) begin
						state_q <= ST_MED_RD;
					end else begin
						res_q   <= first_q;
						state_q <= ST_DONE;
					end
				end
				ST_DIV: begin
					// Restoring division, one quotient bit per cycle
					rem_q   <= qbit ? alu_y[FW-1:0] : div_shift[FW-1:0];
					dvd_q   <= {dvd_q[SW-2:0], qbit};
					cnt_q   <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						state_q <= ST_SIGN;
					end
				end
				ST_SIGN: begin
					res_q   <= alu_y[SMP_W-1:0];
					state_q <= ST_DONE;
				end
				ST_MED_RD: begin
					state_q <= ST_MED_PAIR;
				end
				ST_MED_PAIR: begin
					if (f_eff[0]) begin
						res_q   <= mem_rdata;
						state_q <= ST_DONE;
					end else begin
						pair_q  <= mem_rdata;
						state_q <= ST_MED_AVG;
					end
				end
				ST_MED_AVG: begin
					// Halve toward zero
					res_q   <= med_adj[SMP_W:1];
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// Hand over once the output register is free
					if (!out_valid_q || !result_stall) begin
						out_valid_q <= 1'b1;
						value_q     <= res_q;
						out_last_q  <= lastf_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// Register write restarts the scan
			if (cfg_hit) begin
				unique case (cfg_index)
					sd_pkg::REG_FACTOR:   factor_q   <= cfg_data[sd_pkg::FACTOR_W-1:0];
					sd_pkg::REG_MODE:     mode_q     <= cfg_data[sd_pkg::MODE_W-1:0];
					sd_pkg::REG_SCAN_LEN: scan_len_q <= cfg_data[sd_pkg::SCAN_LEN_W-1:0];
					default: begin
					end
				endcase
				sum_q  <= '0;
				fill_q <= '0;
				pos_q  <= '0;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign value        = value_q;
	assign last_of_scan = out_last_q;

	`SD_ASSERT_NOW(a_fill_below_factor, clk, arst_n, state_q == ST_IDLE, fill_q < f_eff, "open segment fill not below factor")
	`SD_ASSERT_NOW(a_pos_below_len, clk, arst_n, state_q == ST_IDLE, pos_q < len_eff, "scan position not below scan length")
	`SD_ASSERT_NEXT(a_result_waits, clk, arst_n, (state_q == ST_DONE) && out_valid_q && result_stall, state_q == ST_DONE, "pending result left while output stalled")
	`SD_ASSERT_NOW(a_div_count_live, clk, arst_n, state_q == ST_DIV, cnt_q != '0, "division running with empty bit count")

endmodule
